@@ hdl/ovn_pkg.sv @@
`timescale 1ns / 1ps

package ovn_pkg;

  // Default build parameters
  localparam int DEF_MAX_LOG2_SIZE = 10;
  localparam int DEF_SAMPLE_BITS   = 16;

  // Port field widths
  localparam int INDEX_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int NOISE_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register widths
  localparam int LOG2_W   = 4;
  localparam int OCT_W    = 4;
  localparam int SMOOTH_W = 16;

  // Effective size and octave values, one bit above the register width
  localparam int LG_W = LOG2_W + 1;

  // Weight is unsigned Q1.16, the running weight total needs four more bits
  localparam int WW = 17;
  localparam int TW = WW + 4;

  localparam logic [WW-1:0]       WEIGHT_ONE = WW'(65536);
  localparam logic [SMOOTH_W-1:0] SMOOTH_MIN = SMOOTH_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHNESS   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [LOG2_W-1:0]   RST_SIZE_LOG2    = 4'd10;
  localparam logic [OCT_W-1:0]    RST_OCTAVE_COUNT = 4'd4;
  localparam logic [SMOOTH_W-1:0] RST_SMOOTHNESS   = 16'd512;

  // Input item modes
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

endpackage

@@ hdl/octave_value_noise_1d.sv @@
`timescale 1ns / 1ps

// One-dimensional octave value noise. Send a write transaction (mode 0) to
// store a Q0.16 seed sample at index modulo the active size; it finishes in
// the cycle it is accepted and returns nothing. Send a compute transaction
// (mode 1) to get the normalised Q0.16 noise value at that index, returned
// with the index modulo the size. Every entry that a compute reads (the
// pitch-aligned positions below the index and one pitch on, for each octave)
// must have been written first; the table has no reset. A compute keeps the
// block busy from acceptance to result, and no new transaction is taken
// until its result is loaded. The work falls on the single shared divider,
// which yields one quotient bit per cycle for each octave weight update and
// for the final normalisation, and on the single read port of the seed table
// and the one shared multiplier, which every octave uses.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while the
// block is idle; indexes beyond the register list are dropped.

module octave_value_noise_1d #(
  parameter int MAX_LOG2_SIZE = ovn_pkg::DEF_MAX_LOG2_SIZE,
  parameter int SAMPLE_BITS   = ovn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_we,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ovn_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [ovn_pkg::INDEX_W-1:0]      in_index,
  input  logic [ovn_pkg::SAMPLE_W-1:0]     in_sample,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ovn_pkg::NOISE_W-1:0]      out_noise,
  output logic [ovn_pkg::INDEX_W-1:0]      out_result_index
);

  localparam int AW    = MAX_LOG2_SIZE;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = SAMPLE_BITS;
  localparam int LG_W  = ovn_pkg::LG_W;
  localparam int WW    = ovn_pkg::WW;
  localparam int TW    = ovn_pkg::TW;
  // Multiplier: sample by pitch-sized factor or by weight
  localparam int MBW   = (AW + 1 > WW) ? AW + 1 : WW;
  localparam int PW    = SW + MBW;
  // Interpolation sum, accumulator, and divider widths
  localparam int IPW   = SW + AW + 1;
  localparam int ACCW  = SW + TW;
  localparam int QW    = (SW > WW) ? SW : WW;
  localparam int RW    = TW + 1;
  localparam int CW    = $clog2(QW);
  localparam int WNW   = WW + 8 + 1;

  localparam logic [LG_W-1:0] MAX_LG = LG_W'(MAX_LOG2_SIZE);
  localparam logic [LG_W-1:0] ONE_LG = LG_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_MULA,
    S_MULB,
    S_SHIFT,
    S_MULW,
    S_ACC,
    S_WDIV,
    S_WNEXT,
    S_FLOAD,
    S_FDIV,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [ovn_pkg::LOG2_W-1:0]   cfg_size_log2_r;
  logic [ovn_pkg::OCT_W-1:0]    cfg_octave_count_r;
  logic [ovn_pkg::SMOOTH_W-1:0] cfg_smooth_r;

  // Seed table
  logic [SW-1:0] seed_mem [DEPTH];
  logic [SW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          mem_we;

  // Item and octave state
  logic [AW-1:0]   idx_r;
  logic [LG_W-1:0] o_r;
  logic [WW-1:0]   w_r;
  logic [TW-1:0]   tot_r;
  logic [ACCW-1:0] acc_r;
  logic [SW-1:0]   a_r;
  logic [SW-1:0]   b_r;
  logic [SW-1:0]   s_r;
  logic [IPW-1:0]  interp_r;
  logic [PW-1:0]   mul_p_r;

  // Divider
  logic [RW-1:0] div_rem_r;
  logic [QW-1:0] div_num_r;
  logic [TW-1:0] div_den_r;
  logic [CW-1:0] div_cnt_r;

  // Output register
  logic                        out_valid_r;
  logic [ovn_pkg::NOISE_W-1:0] out_noise_r;
  logic [ovn_pkg::INDEX_W-1:0] out_result_index_r;

  // Combinational terms
  logic [LG_W-1:0]              lg;
  logic [LG_W-1:0]              octs;
  logic [ovn_pkg::SMOOTH_W-1:0] smooth;
  logic [AW-1:0]                size_m1;
  logic [LG_W-1:0]              sh;
  logic [AW:0]                  pitch;
  logic [AW:0]                  pitch_m1;
  logic [AW-1:0]                off;
  logic [AW-1:0]                i1;
  logic [AW-1:0]                i2;
  logic [SW-1:0]                mul_a;
  logic [MBW-1:0]               mul_b;
  logic [PW-1:0]                mul_p_nxt;
  logic [IPW-1:0]               ipsum;
  logic [SW-1:0]                s_nxt;
  logic [ACCW-1:0]              acc_nxt;
  logic [ACCW:0]                fnum;
  logic [WNW-1:0]               wnum;
  logic [RW-1:0]                rem_sh;
  logic                         q_bit;
  logic [RW-1:0]                div_rem_nxt;
  logic [QW-1:0]                div_num_nxt;
  logic                         div_last;
  logic                         in_acc;
  logic                         last_oct;

  // Effective size, octave count and smoothness, clamped to their ranges
  always_comb begin
    lg = {1'b0, cfg_size_log2_r};
    if (lg < ONE_LG) begin
      lg = ONE_LG;
    end else if (lg > MAX_LG) begin
      lg = MAX_LG;
    end
    octs = {1'b0, cfg_octave_count_r};
    if (octs < ONE_LG) begin
      octs = ONE_LG;
    end else if (octs > lg) begin
      octs = lg;
    end
    smooth = (cfg_smooth_r < ovn_pkg::SMOOTH_MIN) ? ovn_pkg::SMOOTH_MIN : cfg_smooth_r;
  end

  assign size_m1 = AW'(((AW + 1)'(1) << lg) - (AW + 1)'(1));

  // Octave geometry: pitch, aligned sample pair and offset
  assign sh       = lg - o_r;
  assign pitch    = (AW + 1)'(1) << sh;
  assign pitch_m1 = pitch - (AW + 1)'(1);
  assign off      = idx_r & pitch_m1[AW-1:0];
  assign i1       = idx_r & ~pitch_m1[AW-1:0];
  assign i2       = AW'({1'b0, i1} + pitch) & size_m1;

  assign in_acc   = in_valid && in_ready;
  assign last_oct = (o_r == octs - ONE_LG);

  // Seed table ports
  assign mem_we  = in_acc && (in_mode == ovn_pkg::MODE_WRITE);
  assign wr_addr = AW'(in_index) & size_m1;
  assign rd_addr = (state_r == S_RDA) ? i1 : i2;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seed_mem[wr_addr] <= SW'(in_sample);
    end
    rd_data_r <= seed_mem[rd_addr];
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MULA: begin
        mul_a = a_r;
        mul_b = MBW'(pitch - {1'b0, off});
      end
      S_MULB: begin
        mul_a = b_r;
        mul_b = MBW'(off);
      end
      default: begin
        mul_a = s_r;
        mul_b = MBW'(w_r);
      end
    endcase
    mul_p_nxt = PW'(mul_a) * PW'(mul_b);
  end

  assign ipsum   = interp_r + IPW'(mul_p_r);
  assign s_nxt   = SW'(ipsum >> sh);
  assign acc_nxt = acc_r + ACCW'(mul_p_r);

  // Divider operands: final normalisation and rounded weight update
  assign fnum = {1'b0, acc_r} + (ACCW + 1)'(tot_r >> 1);
  assign wnum = (WNW'(w_r) << 8) + WNW'(smooth >> 1);

  // One restoring division step
  always_comb begin
    rem_sh      = {div_rem_r[RW-2:0], div_num_r[QW-1]};
    q_bit       = (rem_sh >= {1'b0, div_den_r});
    div_rem_nxt = q_bit ? (rem_sh - {1'b0, div_den_r}) : rem_sh;
    div_num_nxt = {div_num_r[QW-2:0], q_bit};
  end

  assign div_last = (div_cnt_r == CW'(QW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      out_valid_r        <= 1'b0;
      cfg_size_log2_r    <= ovn_pkg::RST_SIZE_LOG2;
      cfg_octave_count_r <= ovn_pkg::RST_OCTAVE_COUNT;
      cfg_smooth_r       <= ovn_pkg::RST_SMOOTHNESS;
    end else begin
      // Configuration writes; unknown indexes are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          ovn_pkg::CFG_SIZE_LOG2:    cfg_size_log2_r    <= cfg_wdata[ovn_pkg::LOG2_W-1:0];
          ovn_pkg::CFG_OCTAVE_COUNT: cfg_octave_count_r <= cfg_wdata[ovn_pkg::OCT_W-1:0];
          ovn_pkg::CFG_SMOOTHNESS:   cfg_smooth_r       <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once taken; a finishing compute reloads it instead
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          // Write transactions finish here; computes start the octave loop
          if (in_acc && (in_mode == ovn_pkg::MODE_COMPUTE)) begin
            idx_r   <= AW'(in_index) & size_m1;
            o_r     <= '0;
            w_r     <= ovn_pkg::WEIGHT_ONE;
            tot_r   <= '0;
            acc_r   <= '0;
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          a_r     <= rd_data_r;
          state_r <= S_MULA;
        end
        S_MULA: begin
          b_r     <= rd_data_r;
          mul_p_r <= mul_p_nxt;
          state_r <= S_MULB;
        end
        S_MULB: begin
          interp_r <= IPW'(mul_p_r) + IPW'(pitch >> 1);
          mul_p_r  <= mul_p_nxt;
          state_r  <= S_SHIFT;
        end
        S_SHIFT: begin
          s_r     <= s_nxt;
          state_r <= S_MULW;
        end
        S_MULW: begin
          mul_p_r <= mul_p_nxt;
          tot_r   <= tot_r + TW'(w_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_nxt;
          if (last_oct) begin
            state_r <= S_FLOAD;
          end else begin
            // Start the weight update: w * 256 / smoothness, rounded
            div_rem_r <= RW'(wnum >> QW);
            div_num_r <= QW'(wnum);
            div_den_r <= TW'(smooth);
            div_cnt_r <= '0;
            state_r   <= S_WDIV;
          end
        end
        S_WDIV: begin
          div_rem_r <= div_rem_nxt;
          div_num_r <= div_num_nxt;
          div_cnt_r <= div_cnt_r + CW'(1);
          if (div_last) begin
            state_r <= S_WNEXT;
          end
        end
        S_WNEXT: begin
          w_r     <= WW'(div_num_r);
          o_r     <= o_r + ONE_LG;
          state_r <= S_RDA;
        end
        S_FLOAD: begin
          div_rem_r <= RW'(fnum >> QW);
          div_num_r <= QW'(fnum);
          div_den_r <= tot_r;
          div_cnt_r <= '0;
          state_r   <= S_FDIV;
        end
        S_FDIV: begin
          div_rem_r <= div_rem_nxt;
          div_num_r <= div_num_nxt;
          div_cnt_r <= div_cnt_r + CW'(1);
          if (div_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_noise_r        <= ovn_pkg::NOISE_W'(div_num_r);
            out_result_index_r <= ovn_pkg::INDEX_W'(idx_r);
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Take nothing while reset is held
  assign in_ready         = rst_n && (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_noise        = out_noise_r;
  assign out_result_index = out_result_index_r;

  // A compute transaction leaves idle at once
  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == ovn_pkg::MODE_COMPUTE)) |=> (state_r == S_RDA))
    else $error("compute transaction did not start the octave loop");

  // A write transaction keeps the block idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == ovn_pkg::MODE_WRITE)) |=> (state_r == S_IDLE))
    else $error("write transaction left the idle state");

  // Smoothness is at least one, so the weight never grows
  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (w_r <= ovn_pkg::WEIGHT_ONE))
    else $error("octave weight above one");

  // The partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WDIV) || (state_r == S_FDIV)) |-> (div_rem_r < {1'b0, div_den_r}))
    else $error("divider remainder not below divisor");

  // The octave loop never runs past the effective octave count
  a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDA) |-> (o_r < octs))
    else $error("octave counter out of range");

endmodule

@@ verif/noise_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and register ports of the value noise block.
// Keeps a shadow of the seed table and registers, and works out the noise
// value for every compute transaction. Each result is checked against the
// oldest pending one.
module noise_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ovn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_mode,
  input  logic [ovn_pkg::INDEX_W-1:0]  in_index,
  input  logic [ovn_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [ovn_pkg::NOISE_W-1:0]  out_noise,
  input  logic [ovn_pkg::INDEX_W-1:0]  out_result_index,
  output int                          outstanding,
  output int                          errors
);
  import ovn_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1 << DEF_MAX_LOG2_SIZE;
  localparam longint unsigned NOISE_MAX = (64'd1 << NOISE_W) - 1;

  typedef struct packed {
    logic [NOISE_W-1:0] noise;
    logic [INDEX_W-1:0] idx;
  } noise_result_t;

  logic [SAMPLE_W-1:0] seed_copy [TABLE_DEPTH];
  logic [LOG2_W-1:0]   size_log2_r;
  logic [OCT_W-1:0]    octaves_r;
  logic [SMOOTH_W-1:0] smooth_r;
  noise_result_t       pending_noise_q[$];

  initial begin
    errors = 0;
    outstanding = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) seed_copy[i] = '0;
  end

  function automatic int unsigned active_log2();
    if (size_log2_r < 1) return 1;
    if (size_log2_r > DEF_MAX_LOG2_SIZE) return DEF_MAX_LOG2_SIZE;
    return size_log2_r;
  endfunction

  // Weighted octave sum, normalised by the total weight
  function automatic logic [NOISE_W-1:0] octave_noise(input int unsigned pos,
                                                      input int unsigned lg);
    longint unsigned acc, tot, w, a, b, s, r;
    int unsigned size, octs, smooth, sh, pitch, i1, i2, off;
    size   = 1 << lg;
    octs   = (octaves_r < 1) ? 1 : octaves_r;
    octs   = (octs > lg) ? lg : octs;
    smooth = (smooth_r < SMOOTH_MIN) ? SMOOTH_MIN : smooth_r;
    acc = 0;
    tot = 0;
    w   = WEIGHT_ONE;
    for (int unsigned o = 0; o < octs; o++) begin
      sh    = lg - o;
      pitch = 1 << sh;
      i1    = pos & ~(pitch - 1);
      i2    = (i1 + pitch) & (size - 1);
      off   = pos - i1;
      a     = seed_copy[i1];
      b     = seed_copy[i2];
      s     = (a * (pitch - off) + b * off + (pitch >> 1)) >> sh;
      acc  += s * w;
      tot  += w;
      w     = (w * 256 + (smooth >> 1)) / smooth;
    end
    r = (acc + (tot >> 1)) / tot;
    if (r > NOISE_MAX) r = NOISE_MAX;
    return NOISE_W'(r);
  endfunction

  always @(posedge clk) begin
    noise_result_t want, got;
    int unsigned lg, pos;
    if (!rst_n) begin
      size_log2_r = RST_SIZE_LOG2;
      octaves_r   = RST_OCTAVE_COUNT;
      smooth_r    = RST_SMOOTHNESS;
      pending_noise_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_LOG2:    size_log2_r = cfg_wdata[LOG2_W-1:0];
          CFG_OCTAVE_COUNT: octaves_r   = cfg_wdata[OCT_W-1:0];
          CFG_SMOOTHNESS:   smooth_r    = cfg_wdata[SMOOTH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        lg  = active_log2();
        pos = in_index & ((1 << lg) - 1);
        if (in_mode == MODE_WRITE) begin
          seed_copy[pos] = in_sample;
        end else begin
          want.noise = octave_noise(pos, lg);
          want.idx   = INDEX_W'(pos);
          pending_noise_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got.noise = out_noise;
        got.idx   = out_result_index;
        if (pending_noise_q.size() == 0) begin
          $display("%0t: result with none pending: expected nothing, got noise %h index %0d",
                   $time, got.noise, got.idx);
          errors++;
        end else begin
          want = pending_noise_q.pop_front();
          if (got.noise !== want.noise) begin
            $display("%0t: noise mismatch: expected %h, got %h", $time, want.noise, got.noise);
            errors++;
          end
          if (got.idx !== want.idx) begin
            $display("%0t: result_index mismatch: expected %0d, got %0d",
                     $time, want.idx, got.idx);
            errors++;
          end
        end
      end
    end
    outstanding <= pending_noise_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ovn_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int ITEM_TARGET   = 1150;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 8;     // writes retire in their accept cycle
  localparam int DRAIN_CYCLES  = 260;   // beyond the longest compute (ten octaves)
  localparam int LONG_HOLD     = 600;
  localparam int STALL_LIMIT   = 4000;
  localparam int unsigned TABLE_DEPTH = 1 << DEF_MAX_LOG2_SIZE;

  // Register index past the end of the list; the block must drop it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [INDEX_W-1:0]    in_index;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [NOISE_W-1:0]    out_noise;
  logic [INDEX_W-1:0]    out_result_index;
  int                    outstanding;
  int                    errors;

  // Stimulus-side view of the table: which physical entries hold a seed.
  // A compute must never reach an entry that was not written.
  bit          seed_written [TABLE_DEPTH];
  int unsigned cur_lg_raw;
  int unsigned cur_oct_raw;
  int          items_sent = 0;
  bit          burst = 1'b0;
  int          results_seen = 0;

  always #(CLK_HALF) clk = ~clk;

  octave_value_noise_1d i_dut (.*);

  noise_checker i_noise_check (.*);

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen <= results_seen + 1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic int unsigned active_log2();
    if (cur_lg_raw < 1) return 1;
    if (cur_lg_raw > DEF_MAX_LOG2_SIZE) return DEF_MAX_LOG2_SIZE;
    return cur_lg_raw;
  endfunction

  // Put random bits above the active size so the block has to wrap the index
  function automatic logic [INDEX_W-1:0] alias_index(input int unsigned pos);
    int unsigned lg, hi;
    lg = active_log2();
    hi = $urandom_range(0, (1 << (INDEX_W - lg)) - 1);
    return INDEX_W'(pos | (hi << lg));
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high
  // afterwards unless a gap follows, so back-to-back items need no toggle.
  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] smp);
    int gap;
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_index  <= idx;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_seed(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] smp);
    seed_written[idx & ((1 << active_log2()) - 1)] = 1'b1;
    send_item(MODE_WRITE, idx, smp);
  endtask

  // Seed every aligned entry this index reaches over all octaves, then
  // issue the compute itself
  task automatic compute_at(input logic [INDEX_W-1:0] idx);
    int unsigned lg, size, octs, pos, pitch, i1, i2;
    lg   = active_log2();
    size = 1 << lg;
    octs = (cur_oct_raw < 1) ? 1 : cur_oct_raw;
    octs = (octs > lg) ? lg : octs;
    pos  = idx & (size - 1);
    for (int unsigned o = 0; o < octs; o++) begin
      pitch = size >> o;
      i1    = pos & ~(pitch - 1);
      i2    = (i1 + pitch) & (size - 1);
      if (!seed_written[i1]) write_seed(alias_index(i1), SAMPLE_W'($urandom));
      if (!seed_written[i2]) write_seed(alias_index(i2), SAMPLE_W'($urandom));
    end
    send_item(MODE_COMPUTE, idx, SAMPLE_W'($urandom));
  endtask

  // Drop valid, let every pending result come back, then settle.
  // Step one edge first so the count includes the last accepted compute.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back while idle, plus one write to the
  // spare index. Junk goes in the unused upper data bits.
  task automatic set_config(input int unsigned lg, input int unsigned oct,
                            input int unsigned smooth);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SIZE_LOG2;
    cfg_wdata <= {12'($urandom), 4'(lg)};
    @(posedge clk);
    cfg_index <= CFG_OCTAVE_COUNT;
    cfg_wdata <= {12'($urandom), 4'(oct)};
    @(posedge clk);
    cfg_index <= CFG_SMOOTHNESS;
    cfg_wdata <= CFG_DATA_W'(smooth);
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lg_raw  = lg & 4'hF;
    cur_oct_raw = oct & 4'hF;
  endtask

  // Sender: directed items, then random phases, each under its own settings
  initial begin : stimulus
    int unsigned phase, step, phase_end, r_smooth, smooth_pick;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_mode   = MODE_WRITE;
    in_index  = '0;
    in_sample = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) seed_written[i] = 1'b0;
    cur_lg_raw  = RST_SIZE_LOG2;
    cur_oct_raw = RST_OCTAVE_COUNT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 1024 entries, four octaves, smoothness 2.0
    compute_at(10'd300);

    // Small table, sample extremes, index wider than the table
    set_config(3, 3, 256);
    write_seed(10'd0, 16'hFFFF);
    write_seed(10'd1023, 16'h0000);
    write_seed(10'd2, 16'h0000);
    write_seed(10'd4, 16'h8000);
    write_seed(10'd6, 16'h0001);
    compute_at(10'd0);
    compute_at(10'd1023);
    compute_at(10'd5);

    // Size zero counts as one, octaves zero as one, smoothness below one as one
    set_config(0, 0, 100);
    compute_at(10'd1023);
    compute_at(10'd0);

    // Size above the maximum saturates; largest smoothness
    set_config(12, 2, 65535);
    compute_at(10'd1023);
    compute_at(10'd700);

    // Octave count above the size saturates to it
    set_config(4, 9, 257);
    compute_at(10'd15);
    compute_at(10'd9);

    // Random phases: extremes first, then random settings
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: set_config(10, 10, 256);
        1: set_config(1, 1, 65535);
        2: set_config(15, 15, 0);
        3: set_config(4, 15, 300);
        default: begin
          smooth_pick = $urandom_range(0, 3);
          case (smooth_pick)
            0:       r_smooth = $urandom_range(0, 255);
            1:       r_smooth = $urandom_range(256, 1024);
            2:       r_smooth = $urandom_range(0, 65535);
            default: r_smooth = $urandom_range(256, 600);
          endcase
          set_config($urandom_range(0, 15), $urandom_range(0, 15), r_smooth);
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      step = 0;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        // Switch between gapped and back-to-back stretches
        if (step % 30 == 0) burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 55) compute_at(INDEX_W'($urandom));
        else write_seed(INDEX_W'($urandom), SAMPLE_W'($urandom));
        step++;
      end
      burst = 1'b0;
      phase++;
    end

    // Drain: every result back, then watch a while for strays
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: ready runs of random length broken by stalls. Once, after
  // enough results, hold off for a long stretch so the block backs up and
  // stalls its input while the sender keeps offering.
  initial begin : result_sink
    int run_len, stall_len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        stall_len = LONG_HOLD;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
